// ===== hdl/vdu_pkg.sv =====
// Package for the velocity drag update block: widths, codes, shared types
// and saturation helpers. No dependencies.
`default_nettype none
package vdu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int KW            = 48;
    localparam logic [KW-1:0] KCAP = {KW{1'b1}};

    // Item actions
    localparam logic [2:0] ACT_ROW0      = 3'd0;
    localparam logic [2:0] ACT_ROW1      = 3'd1;
    localparam logic [2:0] ACT_ROW2      = 3'd2;
    localparam logic [2:0] ACT_LIN_UNI   = 3'd3;
    localparam logic [2:0] ACT_LIN_AXIS  = 3'd4;
    localparam logic [2:0] ACT_ANG_UNI   = 3'd5;
    localparam logic [2:0] ACT_ANG_AXIS  = 3'd6;
    localparam logic [2:0] ACT_NONE      = 3'd7;

    // Register indexes
    localparam logic [2:0] REG_DENSITY = 3'd0;
    localparam logic [2:0] REG_STEP    = 3'd1;
    localparam logic [2:0] REG_WIND_X  = 3'd2;
    localparam logic [2:0] REG_WIND_Y  = 3'd3;
    localparam logic [2:0] REG_WIND_Z  = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WIND, ST_ROT, ST_SQ, ST_SQRT, ST_BASE, ST_RATIO,
        ST_RWAIT, ST_KMUL, ST_DIV, ST_DWAIT, ST_WADD
    } t_state;

    // Saturate to 32 bit signed, returns {clip, value}
    function automatic logic [32:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end
        if (x < -66'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, x[31:0]};
    endfunction

    // Flat index of matrix element (row, col), row major
    function automatic logic [3:0] ridx(input logic [1:0] r, input logic [1:0] c);
        return 4'({r, 1'b0}) + 4'(r) + 4'(c);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/vdu_mul.sv =====
// Shared 33x33 signed multiplier with registered product.
// Depends on nothing.
`default_nettype none
module vdu_mul (
    input  wire               i_clk,
    input  wire signed [32:0] i_a,
    input  wire signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    logic signed [65:0] r_p;

    // Register product
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// ===== hdl/vdu_div.sv =====
// Restoring divider, one quotient bit per cycle, 64 bit numerator, 49 bit divisor.
// Depends on vdu_pkg.
`default_nettype none
module vdu_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire [63:0]        i_num,
    input  wire [48:0]        i_den,
    output vdu_pkg::t_unit_stat o_stat,
    output logic [63:0]       o_quo
);
    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [48:0] r_rem, r_den;
    logic [63:0] r_q;
    logic [49:0] trial, diff;
    logic        ge;

    assign trial = {r_rem, r_q[63]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    // Control: count 64 steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift in numerator bit, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[48:0] : trial[48:0];
            r_q   <= {r_q[62:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_q;
endmodule
`default_nettype wire

// ===== hdl/vdu_sqrt.sv =====
// Digit-by-digit floor square root of a 64 bit value, one root bit per cycle.
// Depends on vdu_pkg.
`default_nettype none
module vdu_sqrt (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire [63:0]        i_rad,
    output vdu_pkg::t_unit_stat o_stat,
    output logic [31:0]       o_root
);
    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] trial_rem, trial, diff;
    logic        ge;

    assign trial_rem = {r_rem, r_rad[63:62]};
    assign trial     = {2'b00, r_root, 2'b01};
    assign diff      = trial_rem - trial;
    assign ge        = trial_rem >= trial;

    // Control: count 32 steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: bring down two bits, try root*4+1
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= ge ? diff[33:0] : trial_rem[33:0];
            r_root <= {r_root[30:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;
endmodule
`default_nettype wire

// ===== hdl/velocity_drag_update_top.sv =====
// Velocity drag update: sequencer, state and configuration registers.
// Depends on vdu_pkg, vdu_mul, vdu_div, vdu_sqrt.
//
// Use: one word on the input stream is either a rotation row load (tuser 0..2,
// stored at once, no result), an ignored code (tuser 7), or a velocity vector
// (tuser 3..6) that yields one output word: updated velocity in tdata, the
// saturation flag in tuser. Configuration (density, step, wind) is to be
// written over the APB port only while the block is idle; the block itself
// does not enforce this. pready is always high. Per axis, a 64-step ratio
// division and a 64-step velocity division run on the shared divider, and
// the item also uses the 32-step square root and the shared multiplier for
// the rotations, squares and 48x48 partial products. Row loads and ignored
// words are taken while idle and leave the block idle. s_axis_tready is high
// only while idle. Reset sets the rotation matrix to identity, density to
// 1.0, step to 1092 and wind to zero, and empties the output register.
// A stalled receiver holds the result in the output register; the next
// velocity word is taken meanwhile and waits at its end until that clears.
`default_nettype none
module velocity_drag_update_top #(
    parameter int FRAC_BITS = vdu_pkg::FRAC_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // APB configuration
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [4:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input stream
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // comp_a[31:0] comp_b[63:32] comp_c[95:64] coef_x[126:96] coef_y[157:127]
    // coef_z[188:158] body_mass[219:189], zero pad [223:220]
    input  wire  [223:0] s_axis_tdata,
    // action[2:0]
    input  wire  [2:0]   s_axis_tuser,
    // Output stream
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // new_x[31:0] new_y[63:32] new_z[95:64]
    output logic [95:0]  m_axis_tdata,
    // clipped[0]
    output logic [0:0]   m_axis_tuser
);
    localparam int KW = vdu_pkg::KW;
    localparam logic signed [65:0] HALF   = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic [48:0]        ONE_49 = 49'd1 << FRAC_BITS;

    // Configuration and matrix state
    logic [30:0]        r_dens, r_step;
    logic signed [31:0] r_wind [3];
    logic signed [31:0] r_rot  [9];

    // Item state
    vdu_pkg::t_state    r_state, n_state;
    logic               r_ph, n_ph;
    logic [1:0]         r_i, n_i, r_j, n_j;
    logic               r_world, n_world, r_kstep, n_kstep;
    logic               r_lin, r_axis, r_clip, n_clip;
    logic signed [31:0] r_v [3], n_v [3], r_b [3], n_b [3];
    logic [30:0]        r_coef [3];
    logic [30:0]        r_mass;
    logic signed [65:0] r_acc, n_acc;
    logic [95:0]        r_big, n_big;
    logic [31:0]        r_speed, n_speed;
    logic [KW-1:0]      r_base, n_base, r_ratio, n_ratio, r_k, n_k;

    // Output register
    logic               r_ovalid, n_ovalid, r_oclip, n_oclip;
    logic [31:0]        r_out [3], n_out [3];

    // Shared units
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic               div_start, sq_start;
    logic [63:0]        div_num, div_quo, sq_rad;
    logic [48:0]        div_den;
    logic [31:0]        sq_root;
    vdu_pkg::t_unit_stat div_st, sq_st;

    logic accept, cfg_wr;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign cfg_wr = psel && penable && pwrite && pready;

    // 48 bit product cap: {clip, value}
    function automatic logic [KW:0] capq(input logic [95:0] p);
        logic [95:0] s;
        s = p >> FRAC_BITS;
        if (p[95:64] != '0 || s > {48'b0, vdu_pkg::KCAP}) begin
            return {1'b1, vdu_pkg::KCAP};
        end
        return {1'b0, s[KW-1:0]};
    endfunction

    vdu_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    vdu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_st),
        .o_quo   (div_quo)
    );

    vdu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_stat  (sq_st),
        .o_root  (sq_root)
    );

    // Configuration writes and matrix row loads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dens <= 31'd65536;
            r_step <= 31'd1092;
            for (int k = 0; k < 3; k++) begin
                r_wind[k] <= '0;
            end
            for (int k = 0; k < 9; k++) begin
                r_rot[k] <= (k % 4 == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
            end
        end else begin
            if (cfg_wr) begin
                case (paddr[4:2])
                    vdu_pkg::REG_DENSITY: r_dens    <= pwdata[30:0];
                    vdu_pkg::REG_STEP:    r_step    <= pwdata[30:0];
                    vdu_pkg::REG_WIND_X:  r_wind[0] <= pwdata;
                    vdu_pkg::REG_WIND_Y:  r_wind[1] <= pwdata;
                    vdu_pkg::REG_WIND_Z:  r_wind[2] <= pwdata;
                    default: ;
                endcase
            end
            if (accept && s_axis_tuser <= vdu_pkg::ACT_ROW2) begin
                for (int k = 0; k < 3; k++) begin
                    r_rot[vdu_pkg::ridx(s_axis_tuser[1:0], 2'(k))] <=
                        s_axis_tdata[32*k +: 32];
                end
            end
        end
    end

    // Register read back
    always_comb begin
        case (paddr[4:2])
            vdu_pkg::REG_DENSITY: prdata = {1'b0, r_dens};
            vdu_pkg::REG_STEP:    prdata = {1'b0, r_step};
            vdu_pkg::REG_WIND_X:  prdata = r_wind[0];
            vdu_pkg::REG_WIND_Y:  prdata = r_wind[1];
            vdu_pkg::REG_WIND_Z:  prdata = r_wind[2];
            default:              prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // Sequencer: next state, operands and datapath updates
    always_comb begin
        logic [32:0]        sat;
        logic signed [65:0] term, sum;
        logic [3:0]         ri;
        logic [23:0]        xs, ys;
        logic [KW-1:0]      mx, my;
        logic [6:0]         sh;
        logic [95:0]        bnew;
        logic [KW:0]        cq;
        logic [30:0]        c;
        logic [31:0]        mag, q32;
        logic [48:0]        den;

        n_state = r_state;
        n_ph = r_ph;
        n_i = r_i;
        n_j = r_j;
        n_world = r_world;
        n_kstep = r_kstep;
        n_clip = r_clip;
        n_v = r_v;
        n_b = r_b;
        n_acc = r_acc;
        n_big = r_big;
        n_speed = r_speed;
        n_base = r_base;
        n_ratio = r_ratio;
        n_k = r_k;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_oclip = r_oclip;
        n_out = r_out;
        div_start = 1'b0;
        sq_start = 1'b0;

        ri = r_world ? vdu_pkg::ridx(r_i, r_j) : vdu_pkg::ridx(r_j, r_i);
        mx = r_kstep ? r_k : r_base;
        my = r_kstep ? {17'b0, r_step} : r_ratio;
        xs = r_j[1] ? mx[47:24] : mx[23:0];
        ys = r_j[0] ? my[47:24] : my[23:0];
        sh = (r_j[1] ? 7'd24 : 7'd0) + (r_j[0] ? 7'd24 : 7'd0);
        c = r_axis ? r_coef[r_i] : r_coef[0];
        mag = r_b[r_i][31] ? 32'(-33'(r_b[r_i])) : 32'(r_b[r_i]);
        den = {1'b0, r_k} + ONE_49;
        term = (prod + HALF) >>> FRAC_BITS;
        sum = '0;
        sat = '0;
        bnew = '0;
        cq = '0;
        q32 = div_quo[31:0];

        // Multiplier operands by state
        case (r_state)
            vdu_pkg::ST_ROT: begin
                mul_a = 33'(r_rot[ri]);
                mul_b = r_world ? 33'(r_b[r_j]) : 33'(r_v[r_j]);
            end
            vdu_pkg::ST_SQ: begin
                mul_a = 33'(r_b[r_j]);
                mul_b = 33'(r_b[r_j]);
            end
            vdu_pkg::ST_BASE: begin
                mul_a = signed'({1'b0, r_speed});
                mul_b = signed'({2'b0, r_dens});
            end
            default: begin
                mul_a = signed'({9'b0, xs});
                mul_b = signed'({9'b0, ys});
            end
        endcase

        div_num = '0;
        div_den = '0;
        sq_rad = r_acc[63:0] + prod[63:0];

        case (r_state)
            vdu_pkg::ST_IDLE: begin
                if (accept && s_axis_tuser > vdu_pkg::ACT_ROW2 &&
                    s_axis_tuser != vdu_pkg::ACT_NONE) begin
                    n_state = vdu_pkg::ST_WIND;
                    n_clip = 1'b0;
                    for (int k = 0; k < 3; k++) begin
                        n_v[k] = s_axis_tdata[32*k +: 32];
                    end
                end
            end
            vdu_pkg::ST_WIND: begin
                // Subtract wind in linear modes
                if (r_lin) begin
                    for (int k = 0; k < 3; k++) begin
                        sat = vdu_pkg::sat32(66'(r_v[k]) - 66'(r_wind[k]));
                        n_v[k] = sat[31:0];
                        if (sat[32]) n_clip = 1'b1;
                    end
                end
                n_i = '0;
                n_j = '0;
                n_ph = 1'b0;
                n_acc = '0;
                if (r_axis) begin
                    n_world = 1'b0;
                    n_state = vdu_pkg::ST_ROT;
                end else begin
                    n_b = n_v;
                    n_state = vdu_pkg::ST_SQ;
                end
            end
            vdu_pkg::ST_ROT: begin
                // Accumulate rounded matrix products, adding each term on the second phase
                n_ph = !r_ph;
                if (r_ph) begin
                    sum = r_acc + term;
                    if (r_j == 2'd2) begin
                        sat = vdu_pkg::sat32(sum);
                        if (sat[32]) n_clip = 1'b1;
                        if (r_world) n_v[r_i] = sat[31:0];
                        else n_b[r_i] = sat[31:0];
                        n_acc = '0;
                        n_j = '0;
                        if (r_i == 2'd2) begin
                            n_i = '0;
                            n_state = r_world ? vdu_pkg::ST_WADD : vdu_pkg::ST_SQ;
                        end else begin
                            n_i = r_i + 2'd1;
                        end
                    end else begin
                        n_acc = sum;
                        n_j = r_j + 2'd1;
                    end
                end
            end
            vdu_pkg::ST_SQ: begin
                // Sum of squares, then start root
                n_ph = !r_ph;
                if (r_ph) begin
                    n_acc = r_acc + prod;
                    if (r_j == 2'd2) begin
                        sq_start = 1'b1;
                        n_j = '0;
                        n_acc = '0;
                        n_state = vdu_pkg::ST_SQRT;
                    end else begin
                        n_j = r_j + 2'd1;
                    end
                end
            end
            vdu_pkg::ST_SQRT: begin
                if (sq_st.done) begin
                    n_speed = sq_root;
                    n_ph = 1'b0;
                    n_state = vdu_pkg::ST_BASE;
                end
            end
            vdu_pkg::ST_BASE: begin
                n_ph = !r_ph;
                if (r_ph) begin
                    cq = capq({30'b0, prod});
                    n_base = cq[KW-1:0];
                    if (cq[KW]) n_clip = 1'b1;
                    n_i = '0;
                    n_state = vdu_pkg::ST_RATIO;
                end
            end
            vdu_pkg::ST_RATIO: begin
                // Coefficient over mass; zero mass saturates
                n_j = '0;
                n_ph = 1'b0;
                n_kstep = 1'b0;
                n_big = '0;
                if (r_mass == '0) begin
                    n_ratio = vdu_pkg::KCAP;
                    n_clip = 1'b1;
                    n_state = vdu_pkg::ST_KMUL;
                end else begin
                    div_start = 1'b1;
                    div_num = {33'b0, c} << FRAC_BITS;
                    div_den = {18'b0, r_mass};
                    n_state = vdu_pkg::ST_RWAIT;
                end
            end
            vdu_pkg::ST_RWAIT: begin
                if (div_st.done) begin
                    if (div_quo > {16'b0, vdu_pkg::KCAP}) begin
                        n_ratio = vdu_pkg::KCAP;
                        n_clip = 1'b1;
                    end else begin
                        n_ratio = div_quo[KW-1:0];
                    end
                    n_state = vdu_pkg::ST_KMUL;
                end
            end
            vdu_pkg::ST_KMUL: begin
                // 48x48 product from four 24x24 partials, capped
                n_ph = !r_ph;
                if (r_ph) begin
                    bnew = r_big + ({48'b0, prod[47:0]} << sh);
                    n_big = bnew;
                    if (r_j == 2'd3) begin
                        cq = capq(bnew);
                        n_k = cq[KW-1:0];
                        if (cq[KW]) n_clip = 1'b1;
                        n_j = '0;
                        n_big = '0;
                        if (r_kstep) begin
                            n_state = vdu_pkg::ST_DIV;
                        end else begin
                            n_kstep = 1'b1;
                        end
                    end else begin
                        n_j = r_j + 2'd1;
                    end
                end
            end
            vdu_pkg::ST_DIV: begin
                // Rounded magnitude over 1 + k
                div_start = 1'b1;
                div_num = ({32'b0, mag} << FRAC_BITS) + {15'b0, den >> 1};
                div_den = den;
                n_state = vdu_pkg::ST_DWAIT;
            end
            vdu_pkg::ST_DWAIT: begin
                if (div_st.done) begin
                    n_b[r_i] = r_b[r_i][31] ? -q32 : q32;
                    if (r_i == 2'd2) begin
                        n_i = '0;
                        n_j = '0;
                        n_ph = 1'b0;
                        n_acc = '0;
                        if (r_axis) begin
                            n_world = 1'b1;
                            n_state = vdu_pkg::ST_ROT;
                        end else begin
                            n_v = n_b;
                            n_state = vdu_pkg::ST_WADD;
                        end
                    end else begin
                        n_i = r_i + 2'd1;
                        n_state = vdu_pkg::ST_RATIO;
                    end
                end
            end
            vdu_pkg::ST_WADD: begin
                // Add wind back in linear modes and hand over once the output register is free
                if (!r_ovalid || m_axis_tready) begin
                    n_oclip = r_clip;
                    for (int k = 0; k < 3; k++) begin
                        if (r_lin) begin
                            sat = vdu_pkg::sat32(66'(r_v[k]) + 66'(r_wind[k]));
                            n_out[k] = sat[31:0];
                            if (sat[32]) n_oclip = 1'b1;
                        end else begin
                            n_out[k] = r_v[k];
                        end
                    end
                    n_ovalid = 1'b1;
                    n_state = vdu_pkg::ST_IDLE;
                end
            end
            default: n_state = vdu_pkg::ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= vdu_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_ph     <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_world  <= 1'b0;
            r_kstep  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_ph     <= n_ph;
            r_i      <= n_i;
            r_j      <= n_j;
            r_world  <= n_world;
            r_kstep  <= n_kstep;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_clip  <= n_clip;
        r_v     <= n_v;
        r_b     <= n_b;
        r_acc   <= n_acc;
        r_big   <= n_big;
        r_speed <= n_speed;
        r_base  <= n_base;
        r_ratio <= n_ratio;
        r_k     <= n_k;
        r_oclip <= n_oclip;
        r_out   <= n_out;
        if (accept) begin
            r_lin  <= (s_axis_tuser == vdu_pkg::ACT_LIN_UNI) ||
                      (s_axis_tuser == vdu_pkg::ACT_LIN_AXIS);
            r_axis <= (s_axis_tuser == vdu_pkg::ACT_LIN_AXIS) ||
                      (s_axis_tuser == vdu_pkg::ACT_ANG_AXIS);
            r_coef[0] <= s_axis_tdata[126:96];
            r_coef[1] <= s_axis_tdata[157:127];
            r_coef[2] <= s_axis_tdata[188:158];
            r_mass    <= s_axis_tdata[219:189];
        end
    end

    assign s_axis_tready = (r_state == vdu_pkg::ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign m_axis_tuser  = r_oclip;

    // Checks
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_st.busy && sq_st.busy))
        else $error("divider and root unit busy together");

    a_vel_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (s_axis_tuser == vdu_pkg::ACT_LIN_UNI ||
                    s_axis_tuser == vdu_pkg::ACT_LIN_AXIS ||
                    s_axis_tuser == vdu_pkg::ACT_ANG_UNI ||
                    s_axis_tuser == vdu_pkg::ACT_ANG_AXIS)) |=> !s_axis_tready)
        else $error("velocity word did not start work");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.done |-> (r_state == vdu_pkg::ST_RWAIT || r_state == vdu_pkg::ST_DWAIT))
        else $error("divider finished outside a wait state");

    a_rot_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vdu_pkg::ST_ROT) |-> (r_i != 2'd3 && r_j != 2'd3))
        else $error("rotation index out of range");
endmodule
`default_nettype wire
